### rtl/core/bgr_pkg.sv
// Package for the bitmap glyph rasterizer: widths, types, glyph ROM and saturating helpers.
package bgr_pkg;

   localparam int COORD_BITS    = 13;
   localparam int ORIGIN_BITS   = 13;
   localparam int SCALE_BITS    = 4;
   localparam int TAG_BITS      = 8;
   localparam int CHAR_BITS     = 8;
   localparam int GLYPH_COLS    = 4;
   localparam int GLYPH_ROWS    = 6;
   localparam int GLYPH_CELLS   = GLYPH_COLS * GLYPH_ROWS;
   localparam int GLYPH_ADVANCE = 5;
   localparam int COL_BITS      = $clog2(GLYPH_COLS);
   localparam int ROW_BITS      = $clog2(GLYPH_ROWS);
   // largest offset is (rows-1)*15 + 15 = 90
   localparam int OFF_BITS      = 7;

   localparam int REQ_BITS      = CHAR_BITS + 1 + 2 * ORIGIN_BITS + SCALE_BITS + 2 * TAG_BITS;
   localparam int REQ_DATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS      = 2 * COORD_BITS + SCALE_BITS + 2 * TAG_BITS;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [OFF_BITS-1:0]          off_type;
   typedef logic [GLYPH_CELLS-1:0]       glyph_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHADOW,
      ST_INK,
      ST_ADVANCE
   } state_type;

   // Rows top to bottom from the MSB; within a row the MSB is the left column.
   function automatic glyph_type glyph_lookup(input logic [CHAR_BITS-1:0] code);
      logic [CHAR_BITS-1:0] ch;
      glyph_type            g;
      ch = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         ch = code - 8'h20;
      end
      case (ch)
         8'h20: g = 24'h000000;
         8'h30: g = 24'h69BD96;
         8'h31: g = 24'h262227;
         8'h32: g = 24'h69124F;
         8'h33: g = 24'hE1611E;
         8'h34: g = 24'h26AF22;
         8'h35: g = 24'hF8E196;
         8'h36: g = 24'h68E996;
         8'h37: g = 24'hF12444;
         8'h38: g = 24'h696996;
         8'h39: g = 24'h699716;
         8'h41: g = 24'h699F99;
         8'h42: g = 24'hE9E99E;
         8'h43: g = 24'h698896;
         8'h44: g = 24'hE9999E;
         8'h45: g = 24'hF8E88F;
         8'h46: g = 24'hF8E888;
         8'h47: g = 24'h698B97;
         8'h48: g = 24'h99F999;
         8'h49: g = 24'h722227;
         8'h4A: g = 24'h111196;
         8'h4B: g = 24'h9ACCA9;
         8'h4C: g = 24'h88888F;
         8'h4D: g = 24'h9FF999;
         8'h4E: g = 24'h9DFB99;
         8'h4F: g = 24'h699996;
         8'h50: g = 24'hE9E888;
         8'h51: g = 24'h699BA5;
         8'h52: g = 24'hE9ECA9;
         8'h53: g = 24'h78611E;
         8'h54: g = 24'hF44444;
         8'h55: g = 24'h999996;
         8'h56: g = 24'h999966;
         8'h57: g = 24'h999FF9;
         8'h58: g = 24'h996699;
         8'h59: g = 24'h996444;
         8'h5A: g = 24'hF1248F;
         8'h2D: g = 24'h00F000;
         8'h2E: g = 24'h000004;
         8'h3A: g = 24'h040040;
         8'h2F: g = 24'h112488;
         8'h25: g = 24'h912489;
         8'h2C: g = 24'h000048;
         8'h27: g = 24'h440000;
         8'h21: g = 24'h444404;
         8'h3F: g = 24'h691202;
         8'h28: g = 24'h244442;
         8'h29: g = 24'h422224;
         8'h3B: g = 24'h040048;
         8'h22: g = 24'hAA0000;
         8'h2B: g = 24'h04E400;
         8'h3E: g = 24'h842248;
         8'h3C: g = 24'h248842;
         8'h2A: g = 24'h0A4A00;
         default: g = '0;
      endcase
      return g;
   endfunction

   // Offset is never negative, so only the upper bound can be crossed.
   function automatic coord_type sat_add(input coord_type base, input off_type off);
      logic [COORD_BITS:0] s;
      coord_type           r;
      s = {base[COORD_BITS-1], base} + {{(COORD_BITS + 1 - OFF_BITS){1'b0}}, off};
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
         r = {1'b0, {(COORD_BITS - 1){1'b1}}};
      end else begin
         r = s[COORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic coord_type sat_origin(input logic signed [ORIGIN_BITS-1:0] v);
      localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
      localparam int CMIN = -CMAX - 1;
      logic signed [31:0] vi;
      vi = 32'(v);
      if (vi > CMAX) begin
         vi = CMAX;
      end else if (vi < CMIN) begin
         vi = CMIN;
      end
      return vi[COORD_BITS-1:0];
   endfunction

endpackage

### rtl/core/bitmap_glyph_rasterizer_top.sv
// Top level of the bitmap glyph rasterizer: glyph scan sequencer with one saturating adder pair.
//
//  channel | ports   | direction | item
//  --------+---------+-----------+---------------------------------------------
//  request | req_*   | in        | one character with origin, scale, tag, alpha
//  result  | rsp_*   | out       | one filled square, shadow or ink
//
// After a character is accepted, the sequencer scans its glyph cells up to the
// last lit dot, L cells (at most 24), emits a shadow and then an ink square for
// each of its P lit dots (at most 16), and then advances the cursor. The single
// saturating x/y adder emits one square per cycle while rsp_tready allows.
// Reset clears the sequencer, the result valid and the cursor to zero.
// A result held by rsp_tready low stalls the sequencer at its next square; req_tready is high in idle only.
module bitmap_glyph_rasterizer_top import bgr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // char_code[7:0], string_start[8], origin_x[21:9], origin_y[34:22],
   // pixel_scale[38:35], colour_tag[46:39], alpha[54:47], zero fill above
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rect_x, rect_y (COORD_BITS each), rect_side[4], colour_out[8],
   // alpha_out[8], from the lowest bit up, zero fill above
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // is_shadow
   output logic                     rsp_tuser,
   // last_of_char
   output logic                     rsp_tlast
);

   localparam int O_START = CHAR_BITS;
   localparam int O_OX    = O_START + 1;
   localparam int O_OY    = O_OX + ORIGIN_BITS;
   localparam int O_SC    = O_OY + ORIGIN_BITS;
   localparam int O_TAG   = O_SC + SCALE_BITS;
   localparam int O_ALPHA = O_TAG + TAG_BITS;

   state_type               state_ff, state_in;
   coord_type               cursor_ff, cursor_in;
   coord_type               oy_ff, oy_in;
   logic [SCALE_BITS-1:0]   sc_ff, sc_in;
   logic [TAG_BITS-1:0]     colour_ff, colour_in;
   logic [TAG_BITS-1:0]     alpha_ff, alpha_in;
   glyph_type               mask_ff, mask_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic [COL_BITS-1:0]     col_ff, col_in;
   off_type                 xoff_ff, xoff_in;
   off_type                 yoff_ff, yoff_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_take;
   logic                    out_free;
   logic                    emit;
   logic                    step;
   logic                    is_last;
   logic [SCALE_BITS-1:0]   req_sc;
   off_type                 sc_off;
   off_type                 unit_x_off;
   off_type                 unit_y_off;
   coord_type               unit_x;
   coord_type               unit_y;
   logic [TAG_BITS+1:0]     alpha3;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sc_off   = off_type'(sc_ff);
   assign is_last  = (mask_ff[GLYPH_CELLS-2:0] == '0);
   assign req_sc   = (req_tdata[O_SC +: SCALE_BITS] == '0) ? SCALE_BITS'(1)
                                                           : req_tdata[O_SC +: SCALE_BITS];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (mask_ff == '0) begin
               state_in = ST_ADVANCE;
            end else if (mask_ff[GLYPH_CELLS-1]) begin
               state_in = ST_SHADOW;
            end
         end
         ST_SHADOW: begin
            if (out_free) begin
               state_in = ST_INK;
            end
         end
         ST_INK: begin
            if (out_free) begin
               state_in = ST_SCAN;
            end
         end
         ST_ADVANCE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      emit       = 1'b0;
      step       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
            step = (mask_ff != '0) && !mask_ff[GLYPH_CELLS-1];
         end
         ST_SHADOW: begin
            emit = out_free;
         end
         ST_INK: begin
            emit = out_free;
            step = out_free;
         end
         ST_ADVANCE: begin
         end
         default: begin
         end
      endcase
   end

   assign req_take = req_tready && req_tvalid;

   // shared saturating adder pair
   always_comb begin
      unit_x_off = xoff_ff;
      unit_y_off = yoff_ff;
      if (state_ff == ST_ADVANCE) begin
         unit_x_off = off_type'(GLYPH_ADVANCE) * sc_off;
      end else if (state_ff == ST_SHADOW) begin
         unit_x_off = xoff_ff + sc_off;
         unit_y_off = yoff_ff + sc_off;
      end
      unit_x = sat_add(cursor_ff, unit_x_off);
      unit_y = sat_add(oy_ff, unit_y_off);
   end

   assign alpha3 = {2'b00, alpha_ff} + {1'b0, alpha_ff, 1'b0};

   // datapath next values
   always_comb begin
      cursor_in    = cursor_ff;
      oy_in        = oy_ff;
      sc_in        = sc_ff;
      colour_in    = colour_ff;
      alpha_in     = alpha_ff;
      mask_in      = mask_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      xoff_in      = xoff_ff;
      yoff_in      = yoff_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (req_take) begin
         if (req_tdata[O_START]) begin
            cursor_in = sat_origin(req_tdata[O_OX +: ORIGIN_BITS]);
         end
         oy_in     = sat_origin(req_tdata[O_OY +: ORIGIN_BITS]);
         sc_in     = req_sc;
         colour_in = req_tdata[O_TAG +: TAG_BITS];
         alpha_in  = req_tdata[O_ALPHA +: TAG_BITS];
         mask_in   = glyph_lookup(req_tdata[CHAR_BITS-1:0]);
         row_in    = '0;
         col_in    = '0;
      end

      // latch the dot offsets when the scan lands on a lit cell
      if (state_ff == ST_SCAN && mask_ff[GLYPH_CELLS-1]) begin
         xoff_in = off_type'(col_ff) * sc_off;
         yoff_in = off_type'(row_ff) * sc_off;
      end

      if (step) begin
         mask_in = {mask_ff[GLYPH_CELLS-2:0], 1'b0};
         if (col_ff == COL_BITS'(GLYPH_COLS - 1)) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[0 +: COORD_BITS]           = unit_x;
         rsp_data_in[COORD_BITS +: COORD_BITS]  = unit_y;
         rsp_data_in[2*COORD_BITS +: SCALE_BITS] = sc_ff;
         if (state_ff == ST_SHADOW) begin
            rsp_data_in[2*COORD_BITS+SCALE_BITS +: TAG_BITS]          = '0;
            rsp_data_in[2*COORD_BITS+SCALE_BITS+TAG_BITS +: TAG_BITS] = alpha3[TAG_BITS+1:2];
            rsp_user_in = 1'b1;
            rsp_last_in = 1'b0;
         end else begin
            rsp_data_in[2*COORD_BITS+SCALE_BITS +: TAG_BITS]          = colour_ff;
            rsp_data_in[2*COORD_BITS+SCALE_BITS+TAG_BITS +: TAG_BITS] = alpha_ff;
            rsp_user_in = 1'b0;
            rsp_last_in = is_last;
         end
      end

      if (state_ff == ST_ADVANCE) begin
         cursor_in = unit_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oy_ff       <= oy_in;
      sc_ff       <= sc_in;
      colour_ff   <= colour_in;
      alpha_ff    <= alpha_in;
      mask_ff     <= mask_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      xoff_ff     <= xoff_in;
      yoff_ff     <= yoff_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
